### hdl/dpfc_pkg.sv
package dpfc_pkg;

    localparam int unsigned PIXEL_W     = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned PAL_REGS    = 4;
    localparam int unsigned MAX_BYTES   = 4;
    localparam int unsigned CNT_W       = $clog2(MAX_BYTES);

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS_BYTE = 3'd0,
        MODE_SWAP16    = 3'd1,
        MODE_RGB444    = 3'd2,
        MODE_RGB332    = 3'd3,
        MODE_GRAY8     = 3'd4,
        MODE_GRAY4     = 3'd5,
        MODE_PALETTE   = 3'd6,
        MODE_UNUSED    = 3'd7
    } format_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FORMAT_MODE = 3'd0,
        REG_PALETTE_0_3 = 3'd1,
        REG_PALETTE_4_7 = 3'd2,
        REG_PALETTE_8_B = 3'd3,
        REG_PALETTE_C_F = 3'd4
    } cfg_reg_t;

    function automatic logic [15:0] gray4_to_rgb565(input logic [3:0] n);
        logic [5:0] g6;
        logic [4:0] g5;
        g6 = {n, n[3:2]};
        g5 = g6[5:1];
        return {g5, g6, g5};
    endfunction

endpackage

### hdl/display_pixel_format_converter_top.sv
// Channel  Direction  Ports                               Contents
// s_axis   in         s_tvalid s_tready s_tdata s_tlast   pixel_data, frame_last
// m_axis   out        m_tvalid m_tready m_tdata m_tlast   out_byte, run_end
//                     m_tuser                             nibble_only, transfer_end
// cfg      in         cfg_wen cfg_index cfg_data          register writes
//
// Each source transaction produces one to four bytes, one byte per cycle on m_axis
// while m_tready is high. Bytes per item: 1 in pass-byte modes, 1 and 2 alternating
// in RGB444 (3 bytes per pair), 2 in swap16, RGB332 and gray8, 4 in gray4 pair and
// palette modes, sent by the one-byte-wide output shifter. Path: input register, then
// the byte shifter; the input register can hold the next item while the shifter sends.
// Reset clears mode, palette, RGB444 pair state and both stages.
// A stall on m_tready holds the shifter; s_tready drops once the input register is full too.
module display_pixel_format_converter_top
    import dpfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,   // [15:0] pixel_data
    input  logic                   s_tlast,   // frame_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic                   m_tlast,   // run_end
    output logic [1:0]             m_tuser,   // [0] nibble_only, [1] transfer_end
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    format_mode_t                              mode_reg;
    logic [PAL_REGS-1:0][CFG_DATA_W-1:0]       pal_reg;
    logic                                      phase_reg;
    logic [3:0]                                blue_reg;
    logic                                      phase_next;
    logic [3:0]                                blue_next;

    logic                                      a_valid_reg;
    logic [PIXEL_W-1:0]                        a_data_reg;
    logic                                      a_last_reg;
    logic                                      a_phase_reg;
    logic [3:0]                                a_blue_reg;

    logic                                      b_valid_reg;
    logic [BYTE_W-1:0]                         b_byte_reg [MAX_BYTES];
    logic [MAX_BYTES-1:0]                      b_nib_reg;
    logic [CNT_W-1:0]                          b_cnt_reg;
    logic                                      b_last_reg;

    logic [BYTE_W-1:0]                         cv_byte [MAX_BYTES];
    logic [MAX_BYTES-1:0]                      cv_nib;
    logic [CNT_W-1:0]                          cv_cnt;

    logic                                      in_fire;
    logic                                      out_fire;
    logic                                      b_done;
    logic                                      b_free;
    logic                                      a_move;

    logic [3:0]                                in_blue;
    logic [7:0]                                lo;
    logic [3:0]                                r4;
    logic [3:0]                                g4;
    logic [3:0]                                b4;
    logic [2:0]                                r3;
    logic [2:0]                                g3;
    logic [1:0]                                b2;
    logic [15:0]                               w0;
    logic [15:0]                               w1;
    logic [3:0]                                idx_hi;
    logic [3:0]                                idx_lo;

    assign out_fire = b_valid_reg & m_tready;
    assign b_done   = out_fire & (b_cnt_reg == '0);
    assign b_free   = ~b_valid_reg | b_done;
    assign a_move   = a_valid_reg & b_free;
    assign s_tready = ~a_valid_reg | b_free;
    assign in_fire  = s_tvalid & s_tready;

    assign m_tvalid   = b_valid_reg;
    assign m_tdata    = b_byte_reg[0];
    assign m_tlast    = (b_cnt_reg == '0);
    assign m_tuser[0] = b_nib_reg[0];
    assign m_tuser[1] = (b_cnt_reg == '0) & b_last_reg;

    // pair state advances at accept unless cfg_wen is high; the input register keeps the state seen by this item
    assign in_blue = s_tdata[4:1];

    always_comb
    begin
        phase_next = phase_reg;
        blue_next  = blue_reg;
        if (mode_reg == MODE_RGB444)
        begin
            if (!phase_reg && !s_tlast)
            begin
                phase_next = 1'b1;
                blue_next  = in_blue;
            end
            else
            begin
                phase_next = 1'b0;
                blue_next  = '0;
            end
        end
        if (s_tlast)
        begin
            phase_next = 1'b0;
            blue_next  = '0;
        end
    end

    always_comb
    begin
        lo     = a_data_reg[7:0];
        r4     = a_data_reg[15:12];
        g4     = a_data_reg[10:7];
        b4     = a_data_reg[4:1];
        r3     = lo[7:5];
        g3     = lo[4:2];
        b2     = lo[1:0];
        idx_hi = lo[7:4];
        idx_lo = lo[3:0];
        w0     = '0;
        w1     = '0;
        cv_nib = '0;
        cv_cnt = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            cv_byte[i] = '0;
        end
        case (mode_reg)
            MODE_SWAP16:
            begin
                cv_byte[0] = a_data_reg[15:8];
                cv_byte[1] = a_data_reg[7:0];
                cv_cnt     = CNT_W'(1);
            end
            MODE_RGB444:
            begin
                if (!a_phase_reg)
                begin
                    cv_byte[0] = {r4, g4};
                    if (a_last_reg)
                    begin
                        cv_byte[1] = {b4, 4'b0000};
                        cv_nib[1]  = 1'b1;
                        cv_cnt     = CNT_W'(1);
                    end
                end
                else
                begin
                    cv_byte[0] = {a_blue_reg, r4};
                    cv_byte[1] = {g4, b4};
                    cv_cnt     = CNT_W'(1);
                end
            end
            MODE_RGB332:
            begin
                w0         = {r3, r3[2:1], g3, g3, b2, b2, b2[1]};
                cv_byte[0] = w0[15:8];
                cv_byte[1] = w0[7:0];
                cv_cnt     = CNT_W'(1);
            end
            MODE_GRAY8:
            begin
                w0         = {lo[7:3], lo[7:2], lo[7:3]};
                cv_byte[0] = w0[15:8];
                cv_byte[1] = w0[7:0];
                cv_cnt     = CNT_W'(1);
            end
            MODE_GRAY4:
            begin
                w0         = gray4_to_rgb565(idx_hi);
                w1         = gray4_to_rgb565(idx_lo);
                cv_byte[0] = w0[15:8];
                cv_byte[1] = w0[7:0];
                cv_byte[2] = w1[15:8];
                cv_byte[3] = w1[7:0];
                cv_cnt     = CNT_W'(3);
            end
            MODE_PALETTE:
            begin
                w0         = pal_reg[idx_hi[3:2]][{idx_hi[1:0], 4'b0000} +: 16];
                w1         = pal_reg[idx_lo[3:2]][{idx_lo[1:0], 4'b0000} +: 16];
                cv_byte[0] = w0[15:8];
                cv_byte[1] = w0[7:0];
                cv_byte[2] = w1[15:8];
                cv_byte[3] = w1[7:0];
                cv_cnt     = CNT_W'(3);
            end
            default:
            begin
                cv_byte[0] = lo;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PASS_BYTE;
            pal_reg   <= '0;
            phase_reg <= 1'b0;
            blue_reg  <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_FORMAT_MODE:
                    begin
                        mode_reg  <= format_mode_t'(cfg_data[MODE_W-1:0]);
                        phase_reg <= 1'b0;
                        blue_reg  <= '0;
                    end
                    REG_PALETTE_0_3: pal_reg[0] <= cfg_data;
                    REG_PALETTE_4_7: pal_reg[1] <= cfg_data;
                    REG_PALETTE_8_B: pal_reg[2] <= cfg_data;
                    REG_PALETTE_C_F: pal_reg[3] <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            else if (in_fire)
            begin
                phase_reg <= phase_next;
                blue_reg  <= blue_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_data_reg  <= s_tdata;
            a_last_reg  <= s_tlast;
            a_phase_reg <= phase_reg;
            a_blue_reg  <= blue_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_cnt_reg   <= '0;
        end
        else if (a_move)
        begin
            b_valid_reg <= 1'b1;
            b_cnt_reg   <= cv_cnt;
        end
        else if (b_done)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            b_cnt_reg <= b_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_byte_reg <= cv_byte;
            b_nib_reg  <= cv_nib;
            b_last_reg <= a_last_reg;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_BYTES - 1; i++)
            begin
                b_byte_reg[i] <= b_byte_reg[i+1];
            end
            b_nib_reg <= {1'b0, b_nib_reg[MAX_BYTES-1:1]};
        end
    end

`ifndef SYNTHESIS
    a_nibble_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tuser[1])
        else $error("nibble_only byte is not the final byte of the transfer");

    a_nibble_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> mode_reg == MODE_RGB444)
        else $error("nibble_only byte outside RGB444 mode");

    a_phase_mode: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> mode_reg == MODE_RGB444)
        else $error("pair phase set outside RGB444 mode");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !m_tlast |=> m_tvalid && b_cnt_reg == $past(b_cnt_reg) - CNT_W'(1))
        else $error("byte burst dropped before its last byte");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_free |=> a_valid_reg && $stable(a_data_reg))
        else $error("input register lost an item while the shifter was busy");
`endif

endmodule
